FILE: design/sorted_priority_list_macros.svh
// Assertion macros shared by the list design.
`ifndef SORTED_PRIORITY_LIST_MACROS_SVH
`define SORTED_PRIORITY_LIST_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define SPL_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sorted list check failed");

// Next-cycle implication, checked on every clock edge outside reset.
`define SPL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sorted list check failed");

`endif

FILE: design/spl_pkg.sv
`default_nettype none

package spl_pkg;

    localparam int KEY_W = 16;
    localparam int PRI_W = 16;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_DELETE = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        STATUS_DONE      = 2'd0,
        STATUS_NOT_FOUND = 2'd1,
        STATUS_FULL      = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DUMP
    } t_state;

    typedef struct packed {
        t_op              op;
        logic [KEY_W-1:0] key;
        logic [PRI_W-1:0] pri;
    } t_req;

endpackage

`default_nettype wire

FILE: design/spl_front.sv
`default_nettype none

module spl_front
    import spl_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_stall,
    input  wire logic             i_req_type,
    input  wire logic [KEY_W-1:0] i_key,
    input  wire logic [PRI_W-1:0] i_priority_req,
    output logic                  o_push,
    output t_req                  o_req,
    input  wire logic             i_q_full
);

    logic r_valid;
    t_req r_req;
    logic take;

    // The stage holds one request and hands it on when the queue has room.
    assign o_stall = r_valid && i_q_full;
    assign take    = i_valid && !o_stall;
    assign o_push  = r_valid && !i_q_full;
    assign o_req   = r_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_req.op  <= (i_req_type == 1'b1) ? OP_DELETE : OP_INSERT;
            r_req.key <= i_key;
            r_req.pri <= (i_req_type == 1'b1) ? '0 : i_priority_req;
        end
    end

endmodule

`default_nettype wire

FILE: design/spl_queue.sv
`default_nettype none

module spl_queue
    import spl_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_req      i_req,
    output logic      o_full,
    output logic      o_valid,
    output t_req      o_req,
    input  wire logic i_pop
);

    t_req       r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_fill;

    assign o_full  = (r_fill == 2'd2);
    assign o_valid = (r_fill != 2'd0);
    assign o_req   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_fill <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= !r_wptr;
            end
            if (i_pop) begin
                r_rptr <= !r_rptr;
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + 2'd1;
            end else if (i_pop && !i_push) begin
                r_fill <= r_fill - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_req;
        end
    end

endmodule

`default_nettype wire

FILE: design/spl_engine.sv
`default_nettype none
`include "sorted_priority_list_macros.svh"

module spl_engine
    import spl_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_q_valid,
    input  t_req                  i_q_req,
    output logic                  o_q_pop,
    output logic                  o_valid,
    input  wire logic             i_stall,
    output logic [1:0]            o_status,
    output logic                  o_entry_valid,
    output logic [KEY_W-1:0]      o_entry_key,
    output logic [PRI_W-1:0]      o_entry_priority,
    output logic                  o_last
);

    localparam int CNTW = $clog2(DEPTH + 1);

    t_state r_state;
    t_state n_state;

    logic [KEY_W-1:0] r_key [DEPTH];
    logic [PRI_W-1:0] r_pri [DEPTH];

    logic [CNTW-1:0]  r_count;
    logic [CNTW-1:0]  r_count_new;
    logic [CNTW-1:0]  r_step;
    t_req             r_req;
    t_status          r_status;
    logic             r_mod;
    logic             r_found;
    logic             r_placed;
    logic [KEY_W-1:0] r_carry_key;
    logic [PRI_W-1:0] r_carry_pri;

    logic             r_out_valid;
    t_status          r_out_status;
    logic             r_out_evalid;
    logic [KEY_W-1:0] r_out_key;
    logic [PRI_W-1:0] r_out_pri;
    logic             r_out_last;

    logic             step_in_old;
    logic             step_end;
    logic             out_free;
    logic             key_hit;
    logic             n_found;
    logic             full;
    logic             rotate;
    logic             take;
    logic             emit_out;
    logic             n_placed;
    logic [KEY_W-1:0] emit_key;
    logic [PRI_W-1:0] emit_pri;
    logic [KEY_W-1:0] tail_key;
    logic [PRI_W-1:0] tail_pri;

    assign step_in_old = (r_step < r_count);
    assign step_end    = (r_step == CNTW'(DEPTH - 1));
    assign out_free    = !r_out_valid || !i_stall;
    assign key_hit     = (r_key[0] == r_req.key);
    assign n_found     = r_found || (step_in_old && key_hit);
    assign full        = (r_count == CNTW'(DEPTH));
    assign emit_out    = (r_step < r_count_new) || ((r_count_new == '0) && (r_step == '0));

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    n_state = (i_q_req.op == OP_DELETE) ? ST_SCAN : ST_DUMP;
                end
            end
            ST_SCAN: begin
                if (step_end) begin
                    n_state = ST_DUMP;
                end
            end
            ST_DUMP: begin
                if (out_free && step_end) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        take     = (r_state == ST_IDLE) && i_q_valid;
        rotate   = (r_state == ST_SCAN) || ((r_state == ST_DUMP) && out_free);
        o_q_pop  = take;
        emit_key = r_key[0];
        emit_pri = r_pri[0];
        n_placed = r_placed;
        if (r_mod && (r_req.op == OP_INSERT)) begin
            if (r_placed) begin
                emit_key = r_carry_key;
                emit_pri = r_carry_pri;
            end else if (!(step_in_old && (r_pri[0] <= r_req.pri))) begin
                emit_key = r_req.key;
                emit_pri = r_req.pri;
                n_placed = 1'b1;
            end
        end else if (r_mod) begin
            if (r_placed || (step_in_old && key_hit)) begin
                emit_key = r_key[1];
                emit_pri = r_pri[1];
                n_placed = 1'b1;
            end
        end
        if (r_state == ST_SCAN) begin
            tail_key = r_key[0];
            tail_pri = r_pri[0];
        end else begin
            tail_key = emit_key;
            tail_pri = emit_pri;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_step      <= '0;
            r_found     <= 1'b0;
            r_placed    <= 1'b0;
            r_mod       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (take) begin
                r_step   <= '0;
                r_found  <= 1'b0;
                r_placed <= 1'b0;
                r_mod    <= (i_q_req.op == OP_INSERT) && !full;
            end else if (r_state == ST_SCAN) begin
                r_found <= n_found;
                r_step  <= step_end ? '0 : r_step + 1'b1;
                if (step_end) begin
                    r_mod <= n_found;
                end
            end else if ((r_state == ST_DUMP) && out_free) begin
                r_placed <= n_placed;
                r_step   <= r_step + 1'b1;
                if (step_end) begin
                    r_count <= r_count_new;
                end
            end
            if ((r_state == ST_DUMP) && out_free) begin
                r_out_valid <= emit_out;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_req <= i_q_req;
            if (i_q_req.op == OP_INSERT) begin
                r_status    <= full ? STATUS_FULL : STATUS_DONE;
                r_count_new <= full ? r_count : r_count + 1'b1;
            end
        end
        if ((r_state == ST_SCAN) && step_end) begin
            r_status    <= n_found ? STATUS_DONE : STATUS_NOT_FOUND;
            r_count_new <= n_found ? r_count - 1'b1 : r_count;
        end
        if (rotate) begin
            for (int j = 0; j < DEPTH - 1; j++) begin
                r_key[j] <= r_key[j+1];
                r_pri[j] <= r_pri[j+1];
            end
            r_key[DEPTH-1] <= tail_key;
            r_pri[DEPTH-1] <= tail_pri;
        end
        if ((r_state == ST_DUMP) && out_free) begin
            r_carry_key <= r_key[0];
            r_carry_pri <= r_pri[0];
            if (emit_out) begin
                r_out_status <= r_status;
                r_out_evalid <= (r_count_new != '0);
                r_out_key    <= (r_count_new != '0) ? emit_key : '0;
                r_out_pri    <= (r_count_new != '0) ? emit_pri : '0;
                r_out_last   <= (r_count_new == '0) || (r_step == r_count_new - 1'b1);
            end
        end
    end

    assign o_valid          = r_out_valid;
    assign o_status         = r_out_status;
    assign o_entry_valid    = r_out_evalid;
    assign o_entry_key      = r_out_key;
    assign o_entry_priority = r_out_pri;
    assign o_last           = r_out_last;

    `SPL_ASSERT_NOW(a_count_range, 1'b1, r_count <= CNTW'(DEPTH))
    `SPL_ASSERT_NOW(a_empty_is_last, r_out_valid && !r_out_evalid, r_out_last)
    `SPL_ASSERT_NEXT(a_count_commit, (r_state == ST_DUMP) && (n_state == ST_IDLE),
        r_count == $past(r_count_new))
    `SPL_ASSERT_NOW(a_full_status, r_out_valid && (r_out_status == STATUS_FULL),
        r_count == CNTW'(DEPTH))

endmodule

`default_nettype wire

FILE: design/sorted_priority_list.sv
// Channel   Handshake           Payload
// request   i_valid / o_stall   i_req_type, i_key, i_priority_req
// result    o_valid / i_stall   o_status, o_entry_valid, o_entry_key,
//                               o_entry_priority, o_last
//
// An insert makes one pass and a delete two passes, each pass being one
// full turn of the entry shift ring, one ring step per cycle unless a stalled result holds the dump.
// A delete first turns the ring once to find the key, then turns it again to dump.
// Reset is synchronous and active low; it empties the list without touching the entries.
// A stalled result holds the dump in place, while three more requests can still be taken.
`default_nettype none

module sorted_priority_list
    import spl_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_stall,
    input  wire logic             i_req_type,
    input  wire logic [KEY_W-1:0] i_key,
    input  wire logic [PRI_W-1:0] i_priority_req,
    output logic                  o_valid,
    input  wire logic             i_stall,
    output logic [1:0]            o_status,
    output logic                  o_entry_valid,
    output logic [KEY_W-1:0]      o_entry_key,
    output logic [PRI_W-1:0]      o_entry_priority,
    output logic                  o_last
);

    logic push;
    t_req front_req;
    logic q_full;
    logic q_valid;
    t_req q_req;
    logic q_pop;

    spl_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_req_type     (i_req_type),
        .i_key          (i_key),
        .i_priority_req (i_priority_req),
        .o_push         (push),
        .o_req          (front_req),
        .i_q_full       (q_full)
    );

    spl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_req   (front_req),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_req   (q_req),
        .i_pop   (q_pop)
    );

    spl_engine #(
        .DEPTH (DEPTH)
    ) u_engine (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_valid        (q_valid),
        .i_q_req          (q_req),
        .o_q_pop          (q_pop),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_status         (o_status),
        .o_entry_valid    (o_entry_valid),
        .o_entry_key      (o_entry_key),
        .o_entry_priority (o_entry_priority),
        .o_last           (o_last)
    );

endmodule

`default_nettype wire
